// ----- rtl/apu_pkg.sv -----
`default_nettype none

package apu_pkg;

    localparam logic [2:0] CFG_FIRST_DECAY  = 3'd0;
    localparam logic [2:0] CFG_SECOND_DECAY = 3'd1;
    localparam logic [2:0] CFG_LEARN_RATE   = 3'd2;
    localparam logic [2:0] CFG_WEIGHT_DECAY = 3'd3;
    localparam logic [2:0] CFG_EPSILON      = 3'd4;

    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [40:0] ADAM_CAP = 41'h100_0000_0000;

    typedef struct packed {
        logic        start;
        logic        op_sqrt;
        logic [63:0] value;
        logic [32:0] divisor;
    } t_iter_cmd;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_iter_rsp;

    typedef struct packed {
        logic [35:0] rem;
        logic [63:0] num;
        logic [63:0] res;
    } t_itst;

endpackage

`default_nettype wire

// ----- rtl/apu_iter.sv -----
`default_nettype none

module apu_iter
    import apu_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_iter_cmd i_cmd,
    output t_iter_rsp      o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic        r_op_sqrt;
    logic [32:0] r_div;
    t_itst       r_st;
    t_itst       w_next;

    function automatic t_itst iter_one(t_itst s, logic sq, logic [32:0] d);
        t_itst       o;
        logic [35:0] trial;
        o = s;
        if (sq) begin
            o.rem = {s.rem[33:0], s.num[63:62]};
            o.num = {s.num[61:0], 2'b00};
            trial = {s.res[33:0], 2'b01};
        end else begin
            o.rem = {s.rem[34:0], s.num[63]};
            o.num = {s.num[62:0], 1'b0};
            trial = {3'b000, d};
        end
        if (o.rem >= trial) begin
            o.rem = o.rem - trial;
            o.res = {s.res[62:0], 1'b1};
        end else begin
            o.res = {s.res[62:0], 1'b0};
        end
        return o;
    endfunction

    assign w_next = iter_one(iter_one(r_st, r_op_sqrt, r_div), r_op_sqrt, r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.op_sqrt ? 5'd15 : 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op_sqrt <= i_cmd.op_sqrt;
            r_div     <= i_cmd.divisor;
            r_st.rem  <= 36'd0;
            r_st.num  <= i_cmd.value;
            r_st.res  <= 64'd0;
        end else if (r_busy) begin
            r_st <= w_next;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_st.res;

endmodule

`default_nettype wire

// ----- rtl/adam_parameter_update_core.sv -----
`default_nettype none

// Adam update with decoupled weight decay, one parameter element per transfer. The first
// and second moments live in one synchronous memory of NUM_PARAMS entries; after reset the
// block clears every entry and stalls its input until done. A new optimizer step adds
// the power updates, a square root and a division for the bias correction, and a zero
// denominator skips the division. The time of an item is set by the shared iterative
// unit that resolves two bits a cycle and then reports completion. Items are processed
// one at a time; a finished result waits in the output register while the next item is
// accepted.
module adam_parameter_update_core
    import apu_pkg::*;
#(
    parameter int NUM_PARAMS = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_new_step,
    input  wire logic [11:0]        i_param_index,
    input  wire logic signed [31:0] i_gradient,
    input  wire logic signed [31:0] i_current_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [11:0]             o_out_index,
    output logic signed [31:0]      o_delta
);

    localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam logic [24:0] RECIP = 25'((2**24 + NUM_PARAMS - 1) / NUM_PARAMS);
    localparam logic signed [43:0] DELTA_MAX = 44'sd2147483647;
    localparam logic signed [43:0] DELTA_MIN = -44'sd2147483648;

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_IDX1 = 5'd2;
    localparam logic [4:0] S_IDX2 = 5'd3;
    localparam logic [4:0] S_POW1 = 5'd4;
    localparam logic [4:0] S_POW2 = 5'd5;
    localparam logic [4:0] S_BSQ  = 5'd6;
    localparam logic [4:0] S_BSQW = 5'd7;
    localparam logic [4:0] S_BDV  = 5'd8;
    localparam logic [4:0] S_BDVW = 5'd9;
    localparam logic [4:0] S_RD   = 5'd10;
    localparam logic [4:0] S_M1A  = 5'd11;
    localparam logic [4:0] S_M1B  = 5'd12;
    localparam logic [4:0] S_M2A  = 5'd13;
    localparam logic [4:0] S_M2B  = 5'd14;
    localparam logic [4:0] S_M2C  = 5'd15;
    localparam logic [4:0] S_SQ   = 5'd16;
    localparam logic [4:0] S_SQW  = 5'd17;
    localparam logic [4:0] S_DV   = 5'd18;
    localparam logic [4:0] S_DVW  = 5'd19;
    localparam logic [4:0] S_AC   = 5'd20;
    localparam logic [4:0] S_PP   = 5'd21;
    localparam logic [4:0] S_DEC  = 5'd22;
    localparam logic [4:0] S_OUT  = 5'd23;

    logic [4:0]  r_state;
    logic [AW-1:0] r_clr;
    logic [15:0] r_b1;
    logic [15:0] r_b2;
    logic [23:0] r_alpha;
    logic [23:0] r_lambda;
    logic [15:0] r_eps;
    logic [31:0] r_p1;
    logic [31:0] r_p2;
    logic [31:0] r_corr;
    logic        r_out_valid;
    logic [11:0] r_out_index;
    logic [31:0] r_delta;

    logic        r_new_step;
    logic [11:0] r_idx_in;
    logic signed [31:0] r_g;
    logic signed [31:0] r_v;
    logic [11:0] r_q;
    logic [AW-1:0] r_addr;
    logic [95:0] r_rd;
    logic signed [49:0] r_t1;
    logic signed [31:0] r_m1;
    logic [63:0] r_g2;
    logic [63:0] r_t2;
    logic [63:0] r_m2;
    logic [32:0] r_den;
    logic [63:0] r_ratio;
    logic [55:0] r_ac;
    logic [119:0] r_acc;
    logic [1:0]  r_pp;
    logic [40:0] r_adam;
    logic [31:0] r_decay;

    logic [95:0] r_mem [NUM_PARAMS];

    t_iter_cmd w_cmd;
    t_iter_rsp w_rsp;

    logic [36:0] w_qp;
    logic [31:0] w_qn;
    logic [31:0] w_rem;
    logic [47:0] w_pw1;
    logic [47:0] w_pw2;
    logic [31:0] w_d1;
    logic [31:0] w_d2;
    logic [31:0] w_gmag;
    logic [31:0] w_m1mag;
    logic [31:0] w_vmag;
    logic signed [48:0] w_pm1;
    logic signed [49:0] w_pg;
    logic signed [49:0] w_sum1;
    logic [16:0] w_c1;
    logic [16:0] w_c2;
    logic [33:0] w_lo;
    logic [63:0] w_m2new;
    logic [31:0] w_pa;
    logic [31:0] w_pb;
    logic [63:0] w_pp;
    logic [6:0]  w_sh;
    logic [63:0] w_hi;
    logic [55:0] w_dp;
    logic signed [43:0] w_sa;
    logic signed [43:0] w_sd;
    logic signed [43:0] w_sum;
    logic        w_mem_we;
    logic [AW-1:0] w_mem_addr;
    logic [95:0] w_mem_data;
    logic        w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    assign w_qp    = 37'(r_idx_in) * 37'(RECIP);
    assign w_qn    = 32'(r_q) * 32'(NUM_PARAMS);
    assign w_rem   = 32'(r_idx_in) - w_qn;
    assign w_pw1   = 48'(r_p1) * 48'(r_b1);
    assign w_pw2   = 48'(r_p2) * 48'(r_b2);
    assign w_d1    = ONE_Q31 - r_p1;
    assign w_d2    = ONE_Q31 - r_p2;
    assign w_gmag  = r_g[31] ? (~r_g + 32'd1) : r_g;
    assign w_m1mag = r_m1[31] ? (~r_m1 + 32'd1) : r_m1;
    assign w_vmag  = r_v[31] ? (~r_v + 32'd1) : r_v;
    assign w_c1    = 17'h10000 - {1'b0, r_b1};
    assign w_c2    = 17'h10000 - {1'b0, r_b2};
    assign w_pm1   = $signed({1'b0, r_b1}) * $signed(r_rd[95:64]);
    assign w_pg    = $signed({1'b0, w_c1}) * r_g;
    assign w_sum1  = r_t1 + w_pg;
    assign w_lo    = 34'(r_b2) * 34'(r_rd[15:0]) + 34'(w_c2) * 34'(r_g2[15:0]);
    assign w_m2new = r_t2 + 64'(w_lo[33:16]);
    assign w_pa    = r_pp[0] ? {8'd0, r_ac[55:32]} : r_ac[31:0];
    assign w_pb    = r_pp[1] ? r_ratio[63:32] : r_ratio[31:0];
    assign w_pp    = 64'(w_pa) * 64'(w_pb);
    assign w_sh    = {r_pp[1] & r_pp[0], r_pp[1] ^ r_pp[0], 5'd0};
    assign w_hi    = r_acc[119:56];
    assign w_dp    = 56'(r_lambda) * 56'(w_vmag);
    assign w_sa    = $signed({3'b000, r_adam});
    assign w_sd    = $signed({12'd0, r_decay});
    assign w_sum   = (r_v[31] ? w_sd : -w_sd) + (r_m1[31] ? w_sa : -w_sa);

    always_comb begin
        w_cmd.start   = 1'b0;
        w_cmd.op_sqrt = 1'b0;
        w_cmd.value   = 64'd0;
        w_cmd.divisor = 33'd0;
        unique case (r_state)
            S_BSQ: begin
                w_cmd.start   = 1'b1;
                w_cmd.op_sqrt = 1'b1;
                w_cmd.value   = {1'b0, w_d2, 31'd0};
            end
            S_BDV: begin
                w_cmd.start   = 1'b1;
                w_cmd.value   = {15'd0, r_den, 16'd0};
                w_cmd.divisor = {1'b0, w_d1};
            end
            S_SQ: begin
                w_cmd.start   = 1'b1;
                w_cmd.op_sqrt = 1'b1;
                w_cmd.value   = r_m2;
            end
            S_DV: begin
                w_cmd.start   = (r_den != 33'd0);
                w_cmd.value   = {w_m1mag, 32'd0};
                w_cmd.divisor = r_den;
            end
            default: begin
            end
        endcase
    end

    apu_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_mem_we   = 1'b0;
        w_mem_addr = r_addr;
        w_mem_data = {r_m1, w_m2new};
        if (r_state == S_CLR) begin
            w_mem_we   = 1'b1;
            w_mem_addr = r_clr;
            w_mem_data = 96'd0;
        end else if (r_state == S_M2C) begin
            w_mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_data;
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_b1        <= 16'd58982;
            r_b2        <= 16'd65470;
            r_alpha     <= 24'd16777;
            r_lambda    <= 24'd0;
            r_eps       <= 16'd1;
            r_p1        <= ONE_Q31;
            r_p2        <= ONE_Q31;
            r_corr      <= ONE_Q16;
            r_out_valid <= 1'b0;
            r_pp        <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FIRST_DECAY:  r_b1     <= i_cfg_data[15:0];
                    CFG_SECOND_DECAY: r_b2     <= i_cfg_data[15:0];
                    CFG_LEARN_RATE:   r_alpha  <= i_cfg_data;
                    CFG_WEIGHT_DECAY: r_lambda <= i_cfg_data;
                    CFG_EPSILON:      r_eps    <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NUM_PARAMS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_IDX1;
                    end
                end
                S_IDX1: r_state <= S_IDX2;
                S_IDX2: r_state <= r_new_step ? S_POW1 : S_RD;
                S_POW1: begin
                    r_p1    <= w_pw1[47:16];
                    r_state <= S_POW2;
                end
                S_POW2: begin
                    r_p2    <= w_pw2[47:16];
                    r_state <= S_BSQ;
                end
                S_BSQ:  r_state <= S_BSQW;
                S_BSQW: begin
                    if (w_rsp.done) begin
                        r_state <= S_BDV;
                    end
                end
                S_BDV:  r_state <= S_BDVW;
                S_BDVW: begin
                    if (w_rsp.done) begin
                        r_corr  <= (w_rsp.result[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                   : w_rsp.result[31:0];
                        r_state <= S_RD;
                    end
                end
                S_RD:  r_state <= S_M1A;
                S_M1A: r_state <= S_M1B;
                S_M1B: r_state <= S_M2A;
                S_M2A: r_state <= S_M2B;
                S_M2B: r_state <= S_M2C;
                S_M2C: r_state <= S_SQ;
                S_SQ:  r_state <= S_SQW;
                S_SQW: begin
                    if (w_rsp.done) begin
                        r_state <= S_DV;
                    end
                end
                S_DV:  r_state <= (r_den == 33'd0) ? S_AC : S_DVW;
                S_DVW: begin
                    if (w_rsp.done) begin
                        r_state <= S_AC;
                    end
                end
                S_AC: begin
                    r_pp    <= 2'd0;
                    r_state <= S_PP;
                end
                S_PP: begin
                    r_pp <= r_pp + 2'd1;
                    if (r_pp == 2'd3) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_new_step <= i_new_step;
                    r_idx_in   <= i_param_index;
                    r_g        <= i_gradient;
                    r_v        <= i_current_value;
                end
            end
            S_IDX1: r_q <= w_qp[35:24];
            S_IDX2: r_addr <= w_rem[AW-1:0];
            S_BSQW: begin
                if (w_rsp.done) begin
                    r_den <= w_rsp.result[32:0];
                end
            end
            S_RD:  r_g2 <= 64'(w_gmag) * 64'(w_gmag);
            S_M1A: r_t1 <= {w_pm1[48], w_pm1};
            S_M1B: r_m1 <= w_sum1[47:16];
            S_M2A: r_t2 <= 64'(r_b2) * 64'(r_rd[63:16]);
            S_M2B: r_t2 <= r_t2 + 64'(w_c2) * 64'(r_g2[63:16]);
            S_M2C: r_m2 <= w_m2new;
            S_SQW: begin
                if (w_rsp.done) begin
                    r_den <= {1'b0, w_rsp.result[31:0]} + {17'd0, r_eps};
                end
            end
            S_DV: begin
                if (r_den == 33'd0) begin
                    r_ratio <= 64'd0;
                end
            end
            S_DVW: begin
                if (w_rsp.done) begin
                    r_ratio <= w_rsp.result;
                end
            end
            S_AC: begin
                r_ac  <= 56'(r_alpha) * 56'(r_corr);
                r_acc <= 120'd0;
            end
            S_PP: r_acc <= r_acc + (120'(w_pp) << w_sh);
            S_DEC: begin
                r_adam  <= (w_hi > 64'(ADAM_CAP)) ? ADAM_CAP : w_hi[40:0];
                r_decay <= w_dp[55:24];
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out_index <= r_idx_in;
                    if (w_sum > DELTA_MAX) begin
                        r_delta <= 32'h7FFF_FFFF;
                    end else if (w_sum < DELTA_MIN) begin
                        r_delta <= 32'h8000_0000;
                    end else begin
                        r_delta <= w_sum[31:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_delta     = r_delta;

endmodule

`default_nettype wire

// ----- rtl/apu_checker.sv -----
`default_nettype none

module apu_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [11:0]        o_out_index,
    input wire logic signed [31:0] o_delta
);

    // The block works on one item at a time, so it stalls right after a transfer in.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_delta) && $stable(o_out_index)))
        else $error("stalled result changed");

    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // The memory clearing pass keeps the input stalled after reset.
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("input open during reset");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while idle");

endmodule

bind adam_parameter_update_core apu_checker u_apu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_index (o_out_index),
    .o_delta     (o_delta)
);

`default_nettype wire

// ----- dv/tb_adam_parameter_update_core.sv -----
module tb_adam_parameter_update_core;
    import apu_pkg::*;

    localparam int NPARAM    = 4096;
    localparam int MAX_CYCLE = 1500000;
    localparam int PHASES    = 6;
    localparam int PER_PHASE = 240;
    localparam int DRAIN     = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = CFG_FIRST_DECAY;
    logic [23:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_new_step = 1'b0;
    logic [11:0]        i_param_index = '0;
    logic signed [31:0] i_gradient = '0;
    logic signed [31:0] i_current_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [11:0]        o_out_index;
    logic signed [31:0] o_delta;

    adam_parameter_update_core #(.NUM_PARAMS(NPARAM)) dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct {
        logic [11:0] idx;
        logic [31:0] delta;
    } delta_t;

    delta_t pending_deltas[$];
    int     err_count = 0;
    int     cycle = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;

    // Shadow copy of the block's registers and state.
    logic [15:0] beta1, beta2, eps;
    logic [23:0] alpha, lambda;
    int          m1_store[NPARAM];
    logic [63:0] m2_store[NPARAM];
    logic [31:0] pow1, pow2, corr;

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] trial;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = res | (64'd1 << b);
            if (trial * trial <= v) begin
                res = trial;
            end
        end
        return res;
    endfunction

    function automatic void step_powers();
        logic [63:0] d1, d2, s, c;
        pow1 = 32'((64'(pow1) * beta1) >> 16);
        pow2 = 32'((64'(pow2) * beta2) >> 16);
        d1 = 64'(ONE_Q31) - 64'(pow1);
        d2 = 64'(ONE_Q31) - 64'(pow2);
        s = root64(d2 << 31);
        if (d1 == 0) begin
            c = 64'hFFFF_FFFF;
        end else begin
            c = (s << 16) / d1;
            if (c > 64'hFFFF_FFFF) begin
                c = 64'hFFFF_FFFF;
            end
        end
        corr = c[31:0];
    endfunction

    function automatic logic [31:0] adamw_delta(logic ns, logic [11:0] idx,
                                                logic signed [31:0] g,
                                                logic signed [31:0] v);
        longint      m1, gs, dl;
        logic [63:0] gmag, g2, m2, c2, den, m1mag, ratio, ac, adam, vmag, decay;
        logic [127:0] prod;
        if (ns) begin
            step_powers();
        end
        gs = longint'(g);
        m1 = (longint'(beta1) * longint'(m1_store[idx]) +
              (65536 - longint'(beta1)) * gs) >>> 16;
        m1_store[idx] = int'(m1);
        gmag = (gs < 0) ? 64'(-gs) : 64'(gs);
        g2 = gmag * gmag;
        m2 = m2_store[idx];
        c2 = 64'd65536 - 64'(beta2);
        m2 = 64'(beta2) * (m2 >> 16) + c2 * (g2 >> 16) +
             ((64'(beta2) * (m2 & 64'hFFFF) + c2 * (g2 & 64'hFFFF)) >> 16);
        m2_store[idx] = m2;
        den = root64(m2) + 64'(eps);
        m1mag = (m1 < 0) ? 64'(-m1) : 64'(m1);
        if (den == 0) begin
            adam = 0;
        end else begin
            ratio = (m1mag << 32) / den;
            ac = 64'(alpha) * 64'(corr);
            prod = 128'(ac) * 128'(ratio);
            prod = prod >> 56;
            adam = (prod > 128'(ADAM_CAP)) ? 64'(ADAM_CAP) : prod[63:0];
        end
        vmag = (v < 0) ? 64'(-longint'(v)) : 64'(longint'(v));
        decay = (64'(lambda) * vmag) >> 24;
        dl = (v < 0) ? longint'(decay) : -longint'(decay);
        dl += (m1 < 0) ? longint'(adam) : -longint'(adam);
        if (dl > 64'sd2147483647) dl = 64'sd2147483647;
        if (dl < -64'sd2147483648) dl = -64'sd2147483648;
        return dl[31:0];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h (cycle %0d)", what, want, got, cycle);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("tb_adam_parameter_update_core: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        delta_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_deltas.size() == 0) begin
                report_mismatch("unexpected transfer", '0, o_delta);
            end else begin
                want = pending_deltas.pop_front();
                if (o_out_index !== want.idx) begin
                    report_mismatch("out_index", 32'(want.idx), 32'(o_out_index));
                end
                if (o_delta !== want.delta) begin
                    report_mismatch("delta", want.delta, o_delta);
                end
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic write_reg(logic [2:0] index, logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (index)
            CFG_FIRST_DECAY:  beta1 = data[15:0];
            CFG_SECOND_DECAY: beta2 = data[15:0];
            CFG_LEARN_RATE:   alpha = data;
            CFG_WEIGHT_DECAY: lambda = data;
            CFG_EPSILON:      eps = data[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] b1, logic [15:0] b2, logic [23:0] lr,
                             logic [23:0] wd, logic [15:0] e);
        write_reg(CFG_FIRST_DECAY, 24'(b1) | (24'($urandom) & 24'hFF0000));
        write_reg(CFG_SECOND_DECAY, 24'(b2));
        write_reg(CFG_LEARN_RATE, lr);
        write_reg(CFG_WEIGHT_DECAY, wd);
        write_reg(CFG_EPSILON, 24'(e));
        write_reg(3'($urandom_range(CFG_EPSILON + 1, 7)), 24'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_deltas.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic send_item(logic ns, logic [11:0] idx, logic [31:0] g, logic [31:0] v,
                             logic typed, logic [31:0] typed_delta);
        delta_t item;
        i_in_valid <= 1'b1;
        i_new_step <= ns;
        i_param_index <= idx;
        i_gradient <= g;
        i_current_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        item.idx = idx;
        item.delta = adamw_delta(ns, idx, g, v);
        if (typed) begin
            item.delta = typed_delta;
        end
        pending_deltas.push_back(item);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return 32'($signed($urandom_range(0, 32'h80000)) - 32'h40000);
        if (sel < 8) return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            default: return 32'h0;
        endcase
    endfunction

    typedef struct {
        logic        reconf;
        logic        ns;
        logic [11:0] idx;
        logic [31:0] g;
        logic [31:0] v;
        logic        typed;
        logic [31:0] want;
    } row_t;

    row_t directed[] = '{
        '{0, 0, 12'd0,   32'h0,         32'h0,         1, 32'h0},
        '{0, 1, 12'd1,   32'h0,         32'h0,         1, 32'h0},
        '{0, 1, 12'hFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h0},
        '{0, 0, 12'hFFF, 32'h8000_0000, 32'h8000_0000, 0, 32'h0},
        '{0, 0, 12'd2,   32'h0000_0001, 32'hFFFF_FFFF, 0, 32'h0},
        '{0, 0, 12'd2,   32'hFFFF_FFFF, 32'h0000_0001, 0, 32'h0},
        '{0, 1, 12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0, 32'h0},
        '{0, 0, 12'h555, 32'hAAAA_AAAA, 32'h5555_5555, 0, 32'h0},
        '{0, 0, 12'd3,   32'h0001_0000, 32'h0001_0000, 0, 32'h0},
        '{0, 0, 12'd3,   32'hFFFF_0000, 32'hFFFF_0000, 0, 32'h0},
        '{0, 1, 12'hFFF, 32'h0,         32'h0,         0, 32'h0},
        '{1, 0, 12'd100, 32'h0,         32'h0,         1, 32'h0},
        '{0, 1, 12'd101, 32'h0,         32'h7FFF_FFFF, 0, 32'h0},
        '{0, 0, 12'd102, 32'h0,         32'h8000_0000, 0, 32'h0},
        '{0, 1, 12'd103, 32'h7FFF_FFFF, 32'h0,         0, 32'h0},
        '{0, 0, 12'd103, 32'h8000_0000, 32'h8000_0000, 0, 32'h0},
        '{0, 1, 12'd104, 32'h0000_0001, 32'h0,         0, 32'h0},
        '{0, 0, 12'hFFF, 32'h1234_5678, 32'hFEDC_BA98, 0, 32'h0}
    };

    initial begin
        logic [15:0] b1, b2, e;
        logic [23:0] lr, wd;
        logic        ns;
        logic [11:0] idx;
        beta1 = 16'd58982;
        beta2 = 16'd65470;
        alpha = 24'd16777;
        lambda = 24'd0;
        eps = 16'd1;
        foreach (m1_store[k]) begin
            m1_store[k] = 0;
            m2_store[k] = '0;
        end
        pow1 = ONE_Q31;
        pow2 = ONE_Q31;
        corr = ONE_Q16;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            if (directed[r].reconf) begin
                i_in_valid <= 1'b0;
                wait_idle();
                write_all(16'd0, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'd0);
            end
            send_item(directed[r].ns, directed[r].idx, directed[r].g, directed[r].v,
                      directed[r].typed, directed[r].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            i_in_valid <= 1'b0;
            wait_idle();
            case (p)
                0: begin
                    b1 = 16'd58982; b2 = 16'd65470; lr = 24'd16777; wd = 24'd0; e = 16'd1;
                end
                1: begin b1 = 16'hFFFF; b2 = 16'hFFFF; lr = '1; wd = '1; e = '1; end
                2: begin b1 = '0; b2 = '0; lr = '0; wd = '0; e = '0; end
                5: begin
                    b1 = 16'd58982; b2 = 16'd65470; lr = 24'd16777; wd = 24'd1000; e = 16'd1;
                end
                default: begin
                    b1 = 16'($urandom); b2 = 16'($urandom); lr = 24'($urandom);
                    wd = 24'($urandom); e = 16'($urandom);
                end
            endcase
            write_all(b1, b2, lr, wd, e);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 55; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                if (p == 2 && n == PER_PHASE / 2) begin
                    i_in_valid <= 1'b0;
                    while (pending_deltas.size() != 0) @(posedge i_clk);
                end
                ns = ($urandom_range(0, 7) == 0);
                idx = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 31)) : 12'($urandom);
                send_item(ns, idx, pick_word(), pick_word(), 1'b0, 32'h0);
            end
        end

        i_in_valid <= 1'b0;
        wait_idle();
        if (err_count == 0) begin
            $display("tb_adam_parameter_update_core: done, clean");
        end else begin
            $display("tb_adam_parameter_update_core: done, errors");
        end
        $finish;
    end

endmodule
